// ===== hdl/keypad_scan_buzzer_backlight_tick_core_defines.svh =====
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared property wrappers for the keypad scanner core.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_BUZZER_BACKLIGHT_TICK_CORE_DEFINES_SVH
`define KEYPAD_SCAN_BUZZER_BACKLIGHT_TICK_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kpsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner package
// Types, codes and constants shared by the keypad scanner core and its channels.
// ----------------------------------------------------------------------------
package kpsb_pkg;

  localparam int KEY_COUNT            = 17;
  localparam int KEY_BUFFER_DEPTH_DEF = 8;

  // Press counters are kept two keys to a row; the last row holds the scan key.
  localparam int CNT_ROWS   = 9;
  localparam int CNT_ROW_AW = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_BEEP  = 2'd2,
    FUNC_PURGE = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_DEF_BRIGHT  = 3'd1,
    CFG_PWM_PERIOD  = 3'd2,
    CFG_DIM_TIMEOUT = 3'd3,
    CFG_OFF_TIMEOUT = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] CLICK_TICKS   = 16'd20;
  localparam logic [15:0] ERROR_TICKS   = 16'd200;
  localparam logic [15:0] BEEP_BUSY     = 16'd100;
  localparam logic [7:0]  COL_STEP_END  = 8'd16;
  localparam logic [7:0]  SCAN_KEY_STEP = 8'd16;
  localparam logic [7:0]  CHECK_FIRST   = 8'd20;
  localparam logic [7:0]  CHECK_END     = 8'd37;

  localparam logic [7:0]  THRESHOLD_RST   = 8'd10;
  localparam logic [3:0]  DEF_BRIGHT_RST  = 4'd5;
  localparam logic [3:0]  PWM_PERIOD_RST  = 4'd10;
  localparam logic [31:0] DIM_TIMEOUT_RST = 32'd20000;
  localparam logic [31:0] OFF_TIMEOUT_RST = 32'd7200000;

  typedef struct packed {
    func_e       func;
    logic [14:0] beep_ms;
    logic        row_a_pressed;
    logic        row_b_pressed;
    logic        scan_key_pressed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] column_drive;
    logic       buzzer_out;
    logic       backlight_out;
    logic       power_hold;
    logic       key_valid;
    logic [4:0] key_number;
    logic [3:0] keys_waiting;
  } out_item_t;

  // Counter row touched by a tick at the given scan step.
  function automatic logic [CNT_ROW_AW-1:0] cnt_row_of(input logic [7:0] step);
    logic [7:0]            chk;
    logic [CNT_ROW_AW-1:0] row;
    chk = step - CHECK_FIRST;
    if (step < COL_STEP_END) begin
      row = {1'b0, step[3:1]};
    end else if (step == SCAN_KEY_STEP) begin
      row = CNT_ROW_AW'(CNT_ROWS - 1);
    end else begin
      row = chk[4:1];
    end
    return row;
  endfunction

endpackage

// ===== hdl/kpsb_ifs.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner channels
// Valid/ready channels carrying request items in and result items out.
// ----------------------------------------------------------------------------
interface kpsb_in_if;
  logic               valid;
  logic               ready;
  kpsb_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface kpsb_out_if;
  logic                valid;
  logic                ready;
  kpsb_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/keypad_scan_buzzer_backlight_tick_core.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner core
// Keypad scan with press debounce, key buffer, buzzer, backlight PWM and idle
// timers, one request item per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// An item passes stage one and the output register. Throughput: one item per
// cycle unless the output stalls; the press-counter memory is read when an
// item is accepted and written back as it leaves stage one, with forwarding.
// Reset is asynchronous: all control state, timers and pins clear at once, and
// the counter rows read as zero through per-row valid bits, so no clearing pass.
`include "keypad_scan_buzzer_backlight_tick_core_defines.svh"

module keypad_scan_buzzer_backlight_tick_core #(
  parameter int KEY_BUFFER_DEPTH = kpsb_pkg::KEY_BUFFER_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kpsb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kpsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  kpsb_in_if.sink                         in_i,
  kpsb_out_if.source                      out_o
);

  import kpsb_pkg::*;

  // Key buffer address and index widths. The indices must be able to hold
  // the depth itself, since a full buffer has its write index at the depth.
  localparam int KB_AW = (KEY_BUFFER_DEPTH > 1) ? $clog2(KEY_BUFFER_DEPTH) : 1;
  localparam int KB_CW = $clog2(KEY_BUFFER_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must only arrive while the core is idle; the block itself does not enforce this.
  // --------------------------------------------------------------------------
  logic [7:0]  thr_q;
  logic [3:0]  def_bright_q;
  logic [3:0]  period_q;
  logic [31:0] dim_q;
  logic [31:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THRESHOLD_RST;
      def_bright_q <= DEF_BRIGHT_RST;
      period_q     <= PWM_PERIOD_RST;
      dim_q        <= DIM_TIMEOUT_RST;
      off_q        <= OFF_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:   thr_q        <= cfg_data_i[7:0];
        CFG_DEF_BRIGHT:  def_bright_q <= cfg_data_i[3:0];
        CFG_PWM_PERIOD:  period_q     <= cfg_data_i[3:0];
        CFG_DIM_TIMEOUT: dim_q        <= cfg_data_i;
        CFG_OFF_TIMEOUT: off_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage one holds the item whose memory reads are in flight; the
  // output register holds the finished result. Stage one may fill while the
  // output register waits, so the input side keeps moving through one stall.
  // --------------------------------------------------------------------------
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic [7:0] s1_step_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic out_advance;
  logic s1_fire;
  logic in_fire;

  assign out_advance = !out_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && out_advance;
  assign in_i.ready  = !s1_valid_q || out_advance;
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // The scan step only depends on the number of ticks seen, so it advances at
  // acceptance; that lets it address the counter memory ahead of stage one.
  logic [7:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && in_i.item.func == FUNC_TICK) begin
        step_q <= step_q + 8'd1;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i.item;
      s1_step_q <= step_q;
    end
  end

  // --------------------------------------------------------------------------
  // Press counter memory: one row per column pair, two 8-bit counts per row
  // (low byte even key, high byte odd key), the scan key alone in the last row.
  // A row that was never written since reset reads as zero.
  // --------------------------------------------------------------------------
  logic [15:0]           cnt_mem [CNT_ROWS];
  logic [15:0]           cnt_rdata_q;
  logic [CNT_ROWS-1:0]   row_vld_q;
  logic [CNT_ROW_AW-1:0] cnt_raddr;
  logic [CNT_ROW_AW-1:0] cnt_waddr;
  logic                  cnt_we;
  logic [15:0]           cnt_wdata;
  logic                  cnt_fwd_hit_q;
  logic [15:0]           cnt_fwd_data_q;

  assign cnt_raddr = cnt_row_of(step_q);
  assign cnt_waddr = cnt_row_of(s1_step_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  // Key buffer memory. Its contents are undefined until written; the indices
  // guarantee that only written entries are ever returned.
  logic [4:0]       ks_mem [KEY_BUFFER_DEPTH];
  logic [4:0]       ks_rdata_q;
  logic [KB_AW-1:0] ks_raddr;
  logic [KB_AW-1:0] ks_waddr;
  logic             ks_we;
  logic [4:0]       ks_wdata;
  logic             ks_fwd_hit_q;
  logic [4:0]       ks_fwd_data_q;

  logic [KB_CW-1:0] wr_idx_q, wr_idx_d;
  logic [KB_CW-1:0] rd_idx_q, rd_idx_d;

  // The read index is taken after the item leaving stage one has updated it.
  assign ks_raddr = rd_idx_d[KB_AW-1:0];
  assign ks_waddr = wr_idx_q[KB_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ks_rdata_q <= ks_mem[ks_raddr];
    end
    if (ks_we) begin
      ks_mem[ks_waddr] <= ks_wdata;
    end
  end

  // When the item leaving stage one writes the very entry that the arriving
  // item reads in the same edge, the memory returns the old data, so the new
  // data is kept aside and used in place of the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q     <= '0;
      cnt_fwd_hit_q <= 1'b0;
      ks_fwd_hit_q  <= 1'b0;
    end else begin
      if (cnt_we) begin
        row_vld_q[cnt_waddr] <= 1'b1;
      end
      if (in_fire) begin
        cnt_fwd_hit_q <= cnt_we && (cnt_waddr == cnt_raddr);
        ks_fwd_hit_q  <= ks_we && (ks_waddr == ks_raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cnt_fwd_data_q <= cnt_wdata;
      ks_fwd_data_q  <= ks_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Timers, pins and buffer indices, updated as an item leaves stage one.
  // --------------------------------------------------------------------------
  logic [15:0] buzz_q, buzz_d;
  logic [3:0]  pwm_q, pwm_d;
  logic [3:0]  bright_q, bright_d;
  logic [31:0] idle_q, idle_d;
  logic [7:0]  col_q, col_d;
  logic        buzz_pin_q, buzz_pin_d;
  logic        light_q, light_d;
  logic        hold_q, hold_d;

  logic [15:0] row_old;
  logic [15:0] buzz_t;
  logic [4:0]  pwm_c;
  logic [31:0] idle_t;
  logic [3:0]  bright_t;
  logic [4:0]  chk_key;
  logic [7:0]  chk_cnt;
  logic        key_valid;
  logic [4:0]  key_num;
  logic [KB_CW-1:0] waiting;

  assign row_old = cnt_fwd_hit_q ? cnt_fwd_data_q
                 : (row_vld_q[cnt_waddr] ? cnt_rdata_q : 16'd0);

  always_comb begin
    buzz_d     = buzz_q;
    pwm_d      = pwm_q;
    bright_d   = bright_q;
    idle_d     = idle_q;
    col_d      = col_q;
    buzz_pin_d = buzz_pin_q;
    light_d    = light_q;
    hold_d     = hold_q;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    cnt_we     = 1'b0;
    cnt_wdata  = row_old;
    ks_we      = 1'b0;
    buzz_t     = buzz_q;
    pwm_c      = {1'b0, pwm_q};
    idle_t     = idle_q;
    bright_t   = bright_q;
    chk_key    = 5'(s1_step_q - CHECK_FIRST);
    chk_cnt    = chk_key[0] ? row_old[15:8] : row_old[7:0];
    ks_wdata   = chk_key;
    key_valid  = 1'b0;
    key_num    = 5'd0;

    if (s1_fire) begin
      case (s1_item_q.func)
        FUNC_TICK: begin
          // Buzzer countdown; the pin shows its parity.
          if (buzz_q != 16'd0) begin
            buzz_t = buzz_q - 16'd1;
          end
          buzz_pin_d = buzz_t[0];

          // Backlight PWM against the brightness in force before this tick.
          pwm_c = {1'b0, pwm_q} + 5'd1;
          if (pwm_c > {1'b0, period_q}) begin
            pwm_c = 5'd0;
          end
          pwm_d   = pwm_c[3:0];
          light_d = (pwm_c[3:0] < bright_q);

          // Column steps drive one line low and count both rows.
          if (s1_step_q < COL_STEP_END && !s1_step_q[0]) begin
            col_d     = ~(8'd1 << s1_step_q[3:1]);
            cnt_we    = 1'b1;
            cnt_wdata = {s1_item_q.row_b_pressed ? row_old[15:8] + 8'd1 : 8'd0,
                         s1_item_q.row_a_pressed ? row_old[7:0] + 8'd1 : 8'd0};
          end

          if (s1_step_q == SCAN_KEY_STEP) begin
            cnt_we         = 1'b1;
            cnt_wdata[7:0] = s1_item_q.scan_key_pressed ? row_old[7:0] + 8'd1 : 8'd0;
          end

          // Check steps look at one key each and push it when held long enough.
          if (s1_step_q >= CHECK_FIRST && s1_step_q < CHECK_END) begin
            if (chk_cnt > thr_q) begin
              buzz_t = CLICK_TICKS;
              if (wr_idx_q < KB_CW'(KEY_BUFFER_DEPTH)) begin
                ks_we    = 1'b1;
                wr_idx_d = wr_idx_q + KB_CW'(1);
              end else begin
                // Buffer full: the key is dropped with a long error beep.
                buzz_t = ERROR_TICKS;
              end
              cnt_we = 1'b1;
              if (chk_key[0]) begin
                cnt_wdata[15:8] = 8'd0;
              end else begin
                cnt_wdata[7:0] = 8'd0;
              end
              idle_t   = 32'd0;
              bright_t = def_bright_q;
            end
          end

          // Idle counter saturates; it sets the dim and power-off points.
          if (idle_t != '1) begin
            idle_t = idle_t + 32'd1;
          end
          if (idle_t > dim_q) begin
            bright_t = 4'd0;
          end
          if (idle_t > off_q) begin
            hold_d = 1'b0;
          end

          buzz_d   = buzz_t;
          idle_d   = idle_t;
          bright_d = bright_t;
        end

        FUNC_READ: begin
          if (wr_idx_q > rd_idx_q) begin
            key_valid = 1'b1;
            key_num   = ks_fwd_hit_q ? ks_fwd_data_q : ks_rdata_q;
            rd_idx_d  = rd_idx_q + KB_CW'(1);
            // Draining the buffer rewinds both indices.
            if (rd_idx_d == wr_idx_q) begin
              rd_idx_d = '0;
              wr_idx_d = '0;
            end
          end
        end

        FUNC_BEEP: begin
          // A request is ignored while a long beep is still running.
          if (buzz_q < BEEP_BUSY) begin
            buzz_d = {s1_item_q.beep_ms, 1'b0};
          end
        end

        FUNC_PURGE: begin
          wr_idx_d = '0;
          rd_idx_d = '0;
        end

        default: ;
      endcase
    end
  end

  assign waiting = wr_idx_d - rd_idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buzz_q     <= '0;
      pwm_q      <= '0;
      bright_q   <= DEF_BRIGHT_RST;
      idle_q     <= '0;
      col_q      <= '1;
      buzz_pin_q <= 1'b0;
      light_q    <= 1'b0;
      hold_q     <= 1'b1;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
    end else begin
      buzz_q     <= buzz_d;
      pwm_q      <= pwm_d;
      bright_q   <= bright_d;
      idle_q     <= idle_d;
      col_q      <= col_d;
      buzz_pin_q <= buzz_pin_d;
      light_q    <= light_d;
      hold_q     <= hold_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

  // Result register; pins on non-tick items repeat the last tick's values.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_item_q.column_drive  <= col_d;
      out_item_q.buzzer_out    <= buzz_pin_d;
      out_item_q.backlight_out <= light_d;
      out_item_q.power_hold    <= hold_d;
      out_item_q.key_valid     <= key_valid;
      out_item_q.key_number    <= key_num;
      out_item_q.keys_waiting  <= 4'(waiting);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `KPSB_ASSERT_NOW(a_buf_order, 1'b1, (rd_idx_q <= wr_idx_q) && (wr_idx_q <= KB_CW'(KEY_BUFFER_DEPTH)), "key buffer indices out of order")
  `KPSB_ASSERT_NEXT(a_hold_sticky, !hold_q, !hold_q, "power hold rose again after falling")
  `KPSB_ASSERT_NOW(a_no_write_stalled, out_valid_q && !out_o.ready, !cnt_we && !ks_we, "memory written while the result is stalled")
  `KPSB_ASSERT_NOW(a_key_range, out_valid_q && out_item_q.key_valid, out_item_q.key_number < 5'(KEY_COUNT), "returned key index out of range")

endmodule
